FILE: design/fcb_pkg.sv
// Shared types, widths and helper functions for the frustum box cull block.
package fcb_pkg;

  localparam int COORD_W = 16;
  localparam int ENT_W   = 16;
  localparam int ROW_W   = 4 * ENT_W;
  localparam int PL_W    = ENT_W + 1;
  localparam int PROD_W  = 2 * PL_W;
  localparam int CR_W    = PROD_W + 1;
  localparam int TERM_W  = PL_W + CR_W;
  localparam int DEN_W   = TERM_W + 2;
  localparam int NUM_W   = DEN_W + 4;
  localparam int QS_W    = NUM_W + 1;
  localparam int CL_W    = COORD_W + 1;
  localparam int DOT_W   = PL_W + COORD_W;
  localparam int SUM_W   = DOT_W + 2;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int N_PLANE = 6;

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(64'h0000_0000_0000_1000);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(64'h0000_0000_1000_0000);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(64'h0000_1000_0000_0000);
  localparam logic [ROW_W-1:0] ROW3_RST = ROW_W'(64'h1000_0000_0000_0000);

  localparam logic signed [CL_W-1:0] CL_MAX = {1'b0, {(CL_W-1){1'b1}}};
  localparam logic signed [CL_W-1:0] CL_MIN = {1'b1, {(CL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_ROW3 = 3'd3
  } fcb_reg_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CROSS,
    SEQ_DOT,
    SEQ_SUM,
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_ACC
  } fcb_seq_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } fcb_in_t;

  typedef struct packed {
    logic degenerate;
    logic visible;
  } fcb_out_t;

  typedef struct packed {
    fcb_in_t box;
    logic    visible;
  } fcb_beat_t;

  typedef struct packed {
    logic signed [PL_W-1:0] w;
    logic signed [PL_W-1:0] z;
    logic signed [PL_W-1:0] y;
    logic signed [PL_W-1:0] x;
  } fcb_plane_t;

  // Frustum extent summary handed from the corner sequencer to the top level
  typedef struct packed {
    logic                 busy;
    logic                 degenerate;
    logic [2:0][CL_W-1:0] hi_min;
    logic [2:0][CL_W-1:0] lo_max;
  } fcb_face_t;

  // Row 3 plus or minus row k, entry by entry
  function automatic fcb_plane_t make_plane(logic [ROW_W-1:0] r3, logic [ROW_W-1:0] rk,
                                            logic neg);
    fcb_plane_t p;
    logic signed [PL_W-1:0] e [4];
    logic signed [PL_W-1:0] u;
    logic signed [PL_W-1:0] v;
    for (int c = 0; c < 4; c++) begin
      u    = PL_W'($signed(r3[c*ENT_W +: ENT_W]));
      v    = PL_W'($signed(rk[c*ENT_W +: ENT_W]));
      e[c] = neg ? (u - v) : (u + v);
    end
    p.x = e[0];
    p.y = e[1];
    p.z = e[2];
    p.w = e[3];
    return p;
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_pp(logic signed [PL_W-1:0] a,
                                                       logic signed [PL_W-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

  // Saturate a quotient into a range that still orders correctly against any coordinate
  function automatic logic signed [CL_W-1:0] clamp_cl(logic signed [QS_W-1:0] v);
    logic signed [QS_W-1:0] hi_lim;
    logic signed [QS_W-1:0] lo_lim;
    hi_lim = QS_W'(CL_MAX);
    lo_lim = QS_W'(CL_MIN);
    if (v > hi_lim) return CL_MAX;
    if (v < lo_lim) return CL_MIN;
    return CL_W'(v);
  endfunction

endpackage

FILE: design/fcb_plane_cell.sv
// One plane cell of the chain: tests the box against one clip plane and passes it on.
module fcb_plane_cell import fcb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fcb_plane_t plane,
  input  logic       up_valid,
  input  fcb_beat_t  up_beat,
  output logic       up_ready,
  output logic       dn_valid,
  output fcb_beat_t  dn_beat,
  input  logic       dn_ready
);

  logic                     va_r;
  logic                     va_nxt;
  fcb_beat_t                beat_a_r;
  logic signed [DOT_W-1:0]  prod_r [3];
  logic                     vb_r;
  logic                     vb_nxt;
  fcb_beat_t                beat_b_r;
  logic                     ready_a;
  logic                     ready_b;
  logic signed [COORD_W-1:0] sel_x;
  logic signed [COORD_W-1:0] sel_y;
  logic signed [COORD_W-1:0] sel_z;
  logic signed [SUM_W-1:0]  peak_val;

  // Pick the bound that maximizes the plane term on one axis
  function automatic logic signed [COORD_W-1:0] pick(logic signed [PL_W-1:0] k,
                                                     logic signed [COORD_W-1:0] lo,
                                                     logic signed [COORD_W-1:0] hi);
    return (k[PL_W-1] == (lo < hi)) ? lo : hi;
  endfunction

  // Handshake: a stage takes a beat when empty or when it moves on
  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;
  assign va_nxt   = ready_a ? up_valid : va_r;
  assign vb_nxt   = ready_b ? va_r : vb_r;

  assign sel_x = pick(plane.x, up_beat.box.min_x, up_beat.box.max_x);
  assign sel_y = pick(plane.y, up_beat.box.min_y, up_beat.box.max_y);
  assign sel_z = pick(plane.z, up_beat.box.min_z, up_beat.box.max_z);

  // Largest plane value over the eight box corners
  assign peak_val = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
                  + (SUM_W'(plane.w) <<< 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  // Stage A: per-axis products
  always_ff @(posedge clk) begin
    if (ready_a) begin
      beat_a_r  <= up_beat;
      prod_r[0] <= DOT_W'(plane.x) * DOT_W'(sel_x);
      prod_r[1] <= DOT_W'(plane.y) * DOT_W'(sel_y);
      prod_r[2] <= DOT_W'(plane.z) * DOT_W'(sel_z);
    end
  end

  // Stage B: drop visibility when every corner is behind the plane
  always_ff @(posedge clk) begin
    if (ready_b) begin
      beat_b_r.box     <= beat_a_r.box;
      beat_b_r.visible <= beat_a_r.visible && !peak_val[SUM_W-1];
    end
  end

  assign dn_valid = vb_r;
  assign dn_beat  = beat_b_r;

endmodule

FILE: design/fcb_corner_seq.sv
// Frustum corner sequencer: solves the eight plane triples and keeps per-axis extents.
module fcb_corner_seq import fcb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  fcb_plane_t [N_PLANE-1:0]  planes,
  output fcb_face_t                 face
);

  fcb_seq_t                  state_r;
  fcb_seq_t                  state_nxt;
  logic [2:0]                corner_r;
  logic [1:0]                ax_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [PROD_W-1:0]  prod_r [18];
  logic signed [TERM_W-1:0]  term_r [12];
  logic signed [DEN_W-1:0]   den_r;
  logic signed [NUM_W-1:0]   num_r [3];
  logic [DEN_W-1:0]          dmag_r;
  logic [DEN_W-1:0]          rem_r;
  logic [NUM_W-1:0]          quo_r;
  logic                      sgn_r;
  logic                      deg_r;
  logic signed [CL_W-1:0]    hi_min_r [3];
  logic signed [CL_W-1:0]    lo_max_r [3];

  fcb_plane_t                pa;
  fcb_plane_t                pb;
  fcb_plane_t                pc;
  logic signed [CR_W-1:0]    crs [9];
  logic signed [DEN_W-1:0]   den_sum;
  logic signed [DEN_W-1:0]   n_sum [3];
  logic [DEN_W:0]            cand;
  logic                      ge;
  logic signed [QS_W-1:0]    qs;
  logic signed [QS_W-1:0]    fl;
  logic signed [QS_W-1:0]    cl;
  logic signed [CL_W-1:0]    fl_c;
  logic signed [CL_W-1:0]    cl_c;
  logic                      rnz;
  logic                      last_corner;
  logic                      last_ax;
  logic                      div_done;

  assign pa = planes[{2'b00, corner_r[0]}];
  assign pb = planes[3'd2 + {2'b00, corner_r[1]}];
  assign pc = planes[3'd4 + {2'b00, corner_r[2]}];

  // Cross products bc, ca, ab from registered partial products
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crs[i] = CR_W'(prod_r[2*i]) - CR_W'(prod_r[2*i+1]);
    end
  end

  always_comb begin
    den_sum = DEN_W'(term_r[0]) + DEN_W'(term_r[1]) + DEN_W'(term_r[2]);
    for (int a = 0; a < 3; a++) begin
      n_sum[a] = DEN_W'(term_r[3+3*a]) + DEN_W'(term_r[4+3*a]) + DEN_W'(term_r[5+3*a]);
    end
  end

  // One restoring divide step
  assign cand = {rem_r, quo_r[NUM_W-1]};
  assign ge   = cand >= {1'b0, dmag_r};

  // Floor and ceiling of the signed quotient
  assign rnz  = rem_r != '0;
  assign qs   = QS_W'({1'b0, quo_r});
  assign fl   = sgn_r ? (-qs - QS_W'(rnz)) : qs;
  assign cl   = sgn_r ? (-qs) : (qs + QS_W'(rnz));
  assign fl_c = clamp_cl(fl);
  assign cl_c = clamp_cl(cl);

  // Step conditions
  always_comb begin
    last_corner = corner_r == 3'd7;
    last_ax     = ax_r == 2'd2;
    div_done    = cnt_r == CNT_W'(NUM_W - 1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE:  state_nxt = SEQ_IDLE;
      SEQ_CROSS: state_nxt = SEQ_DOT;
      SEQ_DOT:   state_nxt = SEQ_SUM;
      SEQ_SUM: begin
        if (den_sum != '0) state_nxt = SEQ_LOAD;
        else if (last_corner) state_nxt = SEQ_IDLE;
        else state_nxt = SEQ_CROSS;
      end
      SEQ_LOAD:  state_nxt = SEQ_DIV;
      SEQ_DIV:   state_nxt = div_done ? SEQ_ACC : SEQ_DIV;
      SEQ_ACC: begin
        if (!last_ax) state_nxt = SEQ_LOAD;
        else if (last_corner) state_nxt = SEQ_IDLE;
        else state_nxt = SEQ_CROSS;
      end
      default:   state_nxt = SEQ_IDLE;
    endcase
    if (start) state_nxt = SEQ_CROSS;
  end

  // Outputs
  always_comb begin
    face.busy       = start || (state_r != SEQ_IDLE);
    face.degenerate = deg_r;
    for (int a = 0; a < 3; a++) begin
      face.hi_min[a] = hi_min_r[a];
      face.lo_max[a] = lo_max_r[a];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      corner_r <= '0;
      ax_r     <= '0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        corner_r <= '0;
        ax_r     <= '0;
      end else if ((state_r == SEQ_SUM && den_sum == '0) ||
                   (state_r == SEQ_ACC && last_ax)) begin
        corner_r <= corner_r + 3'd1;
        ax_r     <= '0;
      end else if (state_r == SEQ_ACC) begin
        ax_r <= ax_r + 2'd1;
      end
      if (state_r == SEQ_LOAD) cnt_r <= '0;
      else if (state_r == SEQ_DIV) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      deg_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        hi_min_r[a] <= CL_MAX;
        lo_max_r[a] <= CL_MIN;
      end
    end
    unique case (state_r)
      SEQ_CROSS: begin
        prod_r[0]  <= mul_pp(pb.y, pc.z);  prod_r[1]  <= mul_pp(pb.z, pc.y);
        prod_r[2]  <= mul_pp(pb.z, pc.x);  prod_r[3]  <= mul_pp(pb.x, pc.z);
        prod_r[4]  <= mul_pp(pb.x, pc.y);  prod_r[5]  <= mul_pp(pb.y, pc.x);
        prod_r[6]  <= mul_pp(pc.y, pa.z);  prod_r[7]  <= mul_pp(pc.z, pa.y);
        prod_r[8]  <= mul_pp(pc.z, pa.x);  prod_r[9]  <= mul_pp(pc.x, pa.z);
        prod_r[10] <= mul_pp(pc.x, pa.y);  prod_r[11] <= mul_pp(pc.y, pa.x);
        prod_r[12] <= mul_pp(pa.y, pb.z);  prod_r[13] <= mul_pp(pa.z, pb.y);
        prod_r[14] <= mul_pp(pa.z, pb.x);  prod_r[15] <= mul_pp(pa.x, pb.z);
        prod_r[16] <= mul_pp(pa.x, pb.y);  prod_r[17] <= mul_pp(pa.y, pb.x);
      end
      SEQ_DOT: begin
        term_r[0] <= TERM_W'(pa.x) * TERM_W'(crs[0]);
        term_r[1] <= TERM_W'(pa.y) * TERM_W'(crs[1]);
        term_r[2] <= TERM_W'(pa.z) * TERM_W'(crs[2]);
        for (int a = 0; a < 3; a++) begin
          term_r[3+3*a] <= TERM_W'(pa.w) * TERM_W'(crs[a]);
          term_r[4+3*a] <= TERM_W'(pb.w) * TERM_W'(crs[3+a]);
          term_r[5+3*a] <= TERM_W'(pc.w) * TERM_W'(crs[6+a]);
        end
      end
      SEQ_SUM: begin
        den_r <= den_sum;
        for (int a = 0; a < 3; a++) begin
          num_r[a] <= -(NUM_W'(n_sum[a]) <<< 4);
        end
        if (den_sum == '0 && !start) deg_r <= 1'b1;
      end
      SEQ_LOAD: begin
        dmag_r <= den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
        quo_r  <= num_r[ax_r][NUM_W-1] ? NUM_W'(-num_r[ax_r]) : NUM_W'(num_r[ax_r]);
        rem_r  <= '0;
        sgn_r  <= num_r[ax_r][NUM_W-1] ^ den_r[DEN_W-1];
      end
      SEQ_DIV: begin
        rem_r <= ge ? DEN_W'(cand - {1'b0, dmag_r}) : DEN_W'(cand);
        quo_r <= {quo_r[NUM_W-2:0], ge};
      end
      SEQ_ACC: begin
        if (!start) begin
          if (cl_c < hi_min_r[ax_r]) hi_min_r[ax_r] <= cl_c;
          if (fl_c > lo_max_r[ax_r]) lo_max_r[ax_r] <= fl_c;
        end
      end
      default: begin
      end
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_DIV) |-> (dmag_r != '0))
    else $error("divide started with a zero denominator");

  a_floor_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_ACC) |-> ((fl <= cl) && (cl - fl <= QS_W'(1))))
    else $error("corner floor and ceiling disagree");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_DIV) |-> (cnt_r < CNT_W'(NUM_W)))
    else $error("divide step count overran");

endmodule

FILE: design/frustum_box_cull.sv
// Frustum box cull top level: matrix registers, plane cell chain, face test and output stage.
//
// Accepts one box per cycle while in_stall is low and returns one result beat per box, in order,
// through six plane cells of two stages each plus the output register.
// The six clip planes follow the matrix registers directly; the frustum corner extents
// are solved by a sequencer with one restoring divider, one quotient bit per cycle.
// After reset and after every write to a matrix row that sequencer runs through all eight
// corners (degenerate corners skip the divide), and in_stall stays high meanwhile.
// Write the matrix only while no box is in flight.
module frustum_box_cull import fcb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  fcb_in_t          in_data,
  output logic             in_stall,
  output logic             out_valid,
  output fcb_out_t         out_data,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [ROW_W-1:0] cfg_data
);

  logic [ROW_W-1:0]          row_r [4];
  logic                      start_r;
  logic                      start_nxt;
  fcb_plane_t [N_PLANE-1:0]  planes;
  fcb_face_t                 face;
  logic                      cv [N_PLANE+1];
  fcb_beat_t                 cb [N_PLANE+1];
  logic                      cr [N_PLANE+1];
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  fcb_out_t                  out_data_r;
  logic                      load_out;
  logic                      face_cull;
  logic signed [CL_W-1:0]    bmin [3];
  logic signed [CL_W-1:0]    bmax [3];

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW0_RST;
      row_r[1] <= ROW1_RST;
      row_r[2] <= ROW2_RST;
      row_r[3] <= ROW3_RST;
    end else if (cfg_we) begin
      unique case (fcb_reg_t'(cfg_index))
        REG_ROW0: row_r[0] <= cfg_data;
        REG_ROW1: row_r[1] <= cfg_data;
        REG_ROW2: row_r[2] <= cfg_data;
        REG_ROW3: row_r[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Restart corner solving after reset and after a valid write
  always_comb begin
    start_nxt = 1'b0;
    if (cfg_we) begin
      unique case (fcb_reg_t'(cfg_index)) inside
        REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3: start_nxt = 1'b1;
        default: start_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b1;
    else start_r <= start_nxt;
  end

  // Planes: left, right, bottom, top, near, far
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      planes[2*k]   = make_plane(row_r[3], row_r[k], 1'b0);
      planes[2*k+1] = make_plane(row_r[3], row_r[k], 1'b1);
    end
  end

  fcb_corner_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .planes (planes),
    .face   (face)
  );

  // Feed the chain; hold off while corners are being solved
  assign cv[0]         = in_valid && !face.busy;
  assign cb[0].box     = in_data;
  assign cb[0].visible = 1'b1;
  assign in_stall      = face.busy || !cr[0];

  for (genvar g = 0; g < N_PLANE; g++) begin : g_cell
    fcb_plane_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (planes[g]),
      .up_valid (cv[g]),
      .up_beat  (cb[g]),
      .up_ready (cr[g]),
      .dn_valid (cv[g+1]),
      .dn_beat  (cb[g+1]),
      .dn_ready (cr[g+1])
    );
  end

  // Face test against the frustum corner extents
  always_comb begin
    bmin[0] = CL_W'(cb[N_PLANE].box.min_x);
    bmin[1] = CL_W'(cb[N_PLANE].box.min_y);
    bmin[2] = CL_W'(cb[N_PLANE].box.min_z);
    bmax[0] = CL_W'(cb[N_PLANE].box.max_x);
    bmax[1] = CL_W'(cb[N_PLANE].box.max_y);
    bmax[2] = CL_W'(cb[N_PLANE].box.max_z);
    face_cull = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if ($signed(face.hi_min[a]) > bmax[a] || $signed(face.lo_max[a]) < bmin[a]) begin
        face_cull = 1'b1;
      end
    end
    face_cull = face_cull && !face.degenerate;
  end

  // Output register
  assign load_out         = !out_valid_r || !out_stall;
  assign cr[N_PLANE]      = load_out;
  assign out_valid_nxt    = load_out ? cv[N_PLANE] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.visible    <= cb[N_PLANE].visible && !face_cull;
      out_data_r.degenerate <= face.degenerate;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !face.busy)
    else $error("box accepted while corners were being solved");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    face.busy |-> in_stall)
    else $error("input not stalled while corners were being solved");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

FILE: test/tb_frustum_box_cull.sv
// Self-checking testbench for the frustum box cull block: directed boxes, then random phases.
module tb_frustum_box_cull;
  import fcb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEMS_PER_SET  = 155;
  localparam logic [2:0] FIRST_UNUSED_REG = 3'd4;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  fcb_in_t          in_data;
  logic             in_stall;
  logic             out_valid;
  fcb_out_t         out_data;
  logic             out_stall;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [ROW_W-1:0] cfg_data;

  frustum_box_cull dut (.*);

  // matrix rows as the block should hold them
  logic [ROW_W-1:0] matrix [4];
  fcb_out_t         pending_verdicts [$];
  int               errors;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               quiet_cycles;

  typedef struct {
    fcb_in_t  box;
    bit       typed;
    fcb_out_t verdict;
  } box_row_t;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint entry(int r, int c);
    return longint'($signed(matrix[r][c*ENT_W +: ENT_W]));
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) == (d < 0))) q++;
    return q;
  endfunction

  // Plane test, then frustum corner against box face test
  function automatic fcb_out_t cull_verdict(fcb_in_t b);
    fcb_out_t res;
    longint pl [6][4];
    longint bmin [3];
    longint bmax [3];
    longint lo [8][3];
    longint hi [8][3];
    longint pa [4];
    longint pb [4];
    longint pc [4];
    longint bc [3];
    longint ca [3];
    longint ab [3];
    longint den;
    longint n;
    longint d;
    longint x;
    longint y;
    longint z;
    bit all_neg;
    int above;
    int below;
    res.visible = 1'b1;
    res.degenerate = 1'b0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 4; j++) begin
        pl[2*k][j]   = entry(3, j) + entry(k, j);
        pl[2*k+1][j] = entry(3, j) - entry(k, j);
      end
    bmin[0] = b.min_x; bmin[1] = b.min_y; bmin[2] = b.min_z;
    bmax[0] = b.max_x; bmax[1] = b.max_y; bmax[2] = b.max_z;
    for (int k = 0; k < 6; k++) begin
      all_neg = 1'b1;
      for (int j = 0; j < 8; j++) begin
        x = j[0] ? bmax[0] : bmin[0];
        y = j[1] ? bmax[1] : bmin[1];
        z = j[2] ? bmax[2] : bmin[2];
        d = pl[k][0] * x + pl[k][1] * y + pl[k][2] * z + pl[k][3] * 16;
        if (d >= 0) all_neg = 1'b0;
      end
      if (all_neg) res.visible = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      pa = pl[k & 1];
      pb = pl[2 + ((k >> 1) & 1)];
      pc = pl[4 + ((k >> 2) & 1)];
      bc[0] = pb[1]*pc[2] - pb[2]*pc[1];
      bc[1] = pb[2]*pc[0] - pb[0]*pc[2];
      bc[2] = pb[0]*pc[1] - pb[1]*pc[0];
      ca[0] = pc[1]*pa[2] - pc[2]*pa[1];
      ca[1] = pc[2]*pa[0] - pc[0]*pa[2];
      ca[2] = pc[0]*pa[1] - pc[1]*pa[0];
      ab[0] = pa[1]*pb[2] - pa[2]*pb[1];
      ab[1] = pa[2]*pb[0] - pa[0]*pb[2];
      ab[2] = pa[0]*pb[1] - pa[1]*pb[0];
      den = pa[0]*bc[0] + pa[1]*bc[1] + pa[2]*bc[2];
      if (den == 0) begin
        res.degenerate = 1'b1;
        continue;
      end
      for (int a = 0; a < 3; a++) begin
        n = -16 * (pa[3]*bc[a] + pb[3]*ca[a] + pc[3]*ab[a]);
        lo[k][a] = floor_div(n, den);
        hi[k][a] = ceil_div(n, den);
      end
    end
    if (res.visible && !res.degenerate)
      for (int a = 0; a < 3; a++) begin
        above = 0;
        below = 0;
        for (int k = 0; k < 8; k++) begin
          if (hi[k][a] > bmax[a]) above++;
          if (lo[k][a] < bmin[a]) below++;
        end
        if (above == 8 || below == 8) res.visible = 1'b0;
      end
    return res;
  endfunction

  function automatic fcb_in_t make_box(int mn_x, int mn_y, int mn_z, int mx_x, int mx_y,
                                       int mx_z);
    fcb_in_t b;
    b.min_x = COORD_W'(mn_x); b.min_y = COORD_W'(mn_y); b.min_z = COORD_W'(mn_z);
    b.max_x = COORD_W'(mx_x); b.max_y = COORD_W'(mx_y); b.max_z = COORD_W'(mx_z);
    return b;
  endfunction

  // Mostly boxes near the frustum scale, some anywhere in the coordinate range
  function automatic fcb_in_t random_box();
    fcb_in_t b;
    int c;
    int e;
    if ($urandom_range(0, 99) < 40) return fcb_in_t'({$urandom, $urandom, $urandom});
    for (int a = 0; a < 3; a++) begin
      c = $urandom_range(0, 160) - 80;
      e = $urandom_range(0, 40);
      if ($urandom_range(0, 9) == 0) e = -e;
      b[a*COORD_W +: COORD_W]     = COORD_W'(c - e);
      b[(a+3)*COORD_W +: COORD_W] = COORD_W'(c + e);
    end
    return b;
  endfunction

  // Idle at random, present the beat, hold it until accepted
  task automatic send_box(fcb_in_t b, bit typed, fcb_out_t verdict);
    fcb_out_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    want = typed ? verdict : cull_verdict(b);
    if (typed && want != cull_verdict(b)) begin
      $error("directed row disagrees with prediction for box %h", b);
      errors++;
    end
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(want);
  endtask

  // Drop valid and wait until every verdict is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [ROW_W-1:0] val);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < FIRST_UNUSED_REG) matrix[idx] = val;
  endtask

  function automatic logic [ROW_W-1:0] splat(logic [ENT_W-1:0] v);
    return {4{v}};
  endfunction

  function automatic logic [ROW_W-1:0] near_unit_row();
    logic [ROW_W-1:0] r;
    for (int c = 0; c < 4; c++) r[c*ENT_W +: ENT_W] = ENT_W'($urandom_range(0, 8192) - 4096);
    return r;
  endfunction

  // Check each returned beat against the oldest prediction
  always @(posedge clk) begin
    fcb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no prediction waiting");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.visible !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, out_data.visible);
          errors++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, out_data.degenerate);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

  // Watchdog on cycles with no handshake and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("frustum_box_cull regression: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    box_row_t rows [$];
    fcb_out_t vis;
    fcb_out_t culled;
    logic [ROW_W-1:0] mats [6][4];
    errors = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ROW0;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    matrix[0] = ROW0_RST; matrix[1] = ROW1_RST;
    matrix[2] = ROW2_RST; matrix[3] = ROW3_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed boxes against the identity matrix: frustum spans -16..16 in Q12.4
    vis.visible = 1'b1;    vis.degenerate = 1'b0;
    culled.visible = 1'b0; culled.degenerate = 1'b0;
    rows.push_back('{make_box(-8, -8, -8, 8, 8, 8), 1, vis});
    rows.push_back('{make_box(32, -8, -8, 48, 8, 8), 1, culled});
    rows.push_back('{make_box(-48, -8, -8, -32, 8, 8), 1, culled});
    rows.push_back('{make_box(-8, 32, -8, 8, 48, 8), 1, culled});
    rows.push_back('{make_box(-8, -48, -8, 8, -32, 8), 1, culled});
    rows.push_back('{make_box(-8, -8, 32, 8, 8, 48), 1, culled});
    rows.push_back('{make_box(-8, -8, -48, 8, 8, -32), 1, culled});
    rows.push_back('{make_box(-32768, -32768, -32768, 32767, 32767, 32767), 1, vis});
    rows.push_back('{make_box(0, 0, 0, 0, 0, 0), 1, vis});
    rows.push_back('{make_box(32767, 32767, 32767, 32767, 32767, 32767), 1, culled});
    rows.push_back('{make_box(-32768, -32768, -32768, -32768, -32768, -32768), 1, culled});
    rows.push_back('{make_box(8, 8, 8, -8, -8, -8), 0, vis});
    rows.push_back('{make_box(16, -8, -8, 20, 8, 8), 0, vis});
    rows.push_back('{make_box(-20, -8, -8, -16, 8, 8), 0, vis});
    rows.push_back('{make_box(17, 17, 17, 17, 17, 17), 0, vis});
    rows.push_back('{make_box(-17, 0, 0, 17, 0, 0), 0, vis});
    rows.push_back('{make_box(32767, -32768, 0, -32768, 32767, 0), 0, vis});
    foreach (rows[i]) send_box(rows[i].box, rows[i].typed, rows[i].verdict);
    drain();

    // Matrix settings: near unit scale, both extremes, degenerate, zero, fully random
    for (int r = 0; r < 4; r++) begin
      mats[0][r] = near_unit_row();
      mats[1][r] = splat(16'h7fff);
      mats[2][r] = splat(16'h8000);
      mats[4][r] = '0;
      mats[5][r] = {$urandom, $urandom};
    end
    mats[3][0] = '0;
    mats[3][1] = near_unit_row();
    mats[3][2] = near_unit_row();
    mats[3][3] = near_unit_row();

    // Unused register indexes must not disturb the matrix
    for (int k = FIRST_UNUSED_REG; k < 8; k++) write_reg(3'(k), {$urandom, $urandom});

    for (int m = -1; m < 6; m++) begin
      if (m >= 0) begin
        write_reg(REG_ROW0, mats[m][0]);
        write_reg(REG_ROW1, mats[m][1]);
        write_reg(REG_ROW2, mats[m][2]);
        write_reg(REG_ROW3, mats[m][3]);
      end else begin
        write_reg(REG_ROW3, ROW3_RST);
      end
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (i < ITEMS_PER_SET / 3) begin
          tx_idle_pct = 23; rx_idle_pct = 77;
        end else if (i < 2 * ITEMS_PER_SET / 3) begin
          tx_idle_pct = 77; rx_idle_pct = 23;
        end else begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
        // hold off once mid-phase until every verdict is back
        if (i == ITEMS_PER_SET / 2) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
        send_box(random_box(), 0, vis);
      end
      drain();
    end

    if (errors == 0)
      $display("frustum_box_cull regression: pass");
    else
      $display("frustum_box_cull regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
design/fcb_pkg.sv
design/fcb_plane_cell.sv
design/fcb_corner_seq.sv
design/frustum_box_cull.sv
test/tb_frustum_box_cull.sv
